FILE: rtl/core/mpe_pkg.sv
// shared types and constants of the matrix product engine
`timescale 1ns / 1ps

package mpe_pkg;

  localparam int CFG_W     = 4;
  localparam int KIND_W    = 2;
  localparam int VAL_W     = 16;
  localparam int RES_W     = 16;
  localparam int IDX_W     = 3;
  localparam int FRAC_BITS = 12;

  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  localparam logic signed [RES_W-1:0] RES_MAX = 16'sh7FFF;
  localparam logic signed [RES_W-1:0] RES_MIN = 16'sh8000;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
    logic                    error;
    logic                    saturated;
  } out_word_t;

  // clipped matrix dimensions
  typedef struct packed {
    logic [CFG_W-1:0] ar;
    logic [CFG_W-1:0] ac;
    logic [CFG_W-1:0] br;
    logic [CFG_W-1:0] bc;
  } dims_t;

  // controller to datapath
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             rewind;
    logic             entry_init;
    logic             term;
    logic             first;
    logic             last;
    logic             next_col;
    logic             next_row;
    logic             err_emit;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_entry;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic done;
  } sts_t;

  function automatic logic [CFG_W-1:0] clip_dim(input logic [CFG_W-1:0] d,
                                                input logic [CFG_W-1:0] max_d);
    logic [CFG_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = CFG_W'(1);
    end else if (d > max_d) begin
      r = max_d;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mpe_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mpe_ctrl.sv
// sequencer for loads and the row / column / inner-term loops
`timescale 1ns / 1ps

module mpe_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mpe_pkg::dims_t   dims,
  input  logic             in_valid,
  output logic             in_stall,
  input  mpe_pkg::in_word_t in_word,
  input  mpe_pkg::sts_t    sts,
  output mpe_pkg::cmd_t    cmd
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] i_r, i_nxt;
  logic [DIM_W-1:0] j_r, j_nxt;
  logic [DIM_W-1:0] k_r, k_nxt;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             accept;
  logic             k_last, j_last, i_last;

  assign ar = dims.ar[DIM_W-1:0];
  assign ac = dims.ac[DIM_W-1:0];
  assign br = dims.br[DIM_W-1:0];
  assign bc = dims.bc[DIM_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign k_last = (k_r + DIM_W'(1) == ac);
  assign j_last = (j_r + DIM_W'(1) == bc);
  assign i_last = (i_r + DIM_W'(1) == ar);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd            = '0;
    cmd.row        = mpe_pkg::IDX_W'(i_r);
    cmd.col        = mpe_pkg::IDX_W'(j_r);
    cmd.last_entry = i_last && j_last;
    cmd.first      = (k_r == '0);
    cmd.last       = k_last;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.kind)
            mpe_pkg::KIND_LOAD_A: cmd.load_a = 1'b1;
            mpe_pkg::KIND_LOAD_B: cmd.load_b = 1'b1;
            mpe_pkg::KIND_START: begin
              cmd.rewind = 1'b1;
              i_nxt      = '0;
              j_nxt      = '0;
              state_nxt  = ST_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_WAIT: begin
        if (sts.out_free) begin
          if (ac != br) begin
            cmd.err_emit = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.entry_init = 1'b1;
            k_nxt          = '0;
            state_nxt      = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.term = 1'b1;
        k_nxt    = k_r + DIM_W'(1);
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.done) begin
          if (j_last) begin
            if (i_last) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.next_row = 1'b1;
              i_nxt        = i_r + DIM_W'(1);
              j_nxt        = '0;
              state_nxt    = ST_WAIT;
            end
          end else begin
            cmd.next_col = 1'b1;
            j_nxt        = j_r + DIM_W'(1);
            state_nxt    = ST_WAIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

FILE: rtl/core/mpe_dp.sv
// element stores, address generation, multiply-accumulate and result register
`timescale 1ns / 1ps

module mpe_dp #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mpe_pkg::dims_t     dims,
  input  mpe_pkg::in_word_t  in_word,
  input  mpe_pkg::cmd_t      cmd,
  output mpe_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_stall,
  output mpe_pkg::out_word_t out_word
);

  localparam int CAP       = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(CAP);
  localparam int LW        = $clog2(CAP + 1);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int PROD_W    = 2 * ELEM_WIDTH;
  localparam int ACC_W     = PROD_W + DIM_W;
  localparam int SAT_MIN_W = mpe_pkg::FRAC_BITS + mpe_pkg::RES_W + 1;
  localparam int SAT_W     = (ACC_W > SAT_MIN_W) ? ACC_W : SAT_MIN_W;
  localparam int TOP_LO    = mpe_pkg::FRAC_BITS + mpe_pkg::RES_W - 1;

  logic [DIM_W-1:0] ac, bc;
  assign ac = dims.ac[DIM_W-1:0];
  assign bc = dims.bc[DIM_W-1:0];

  // element from the 16-bit field, sign taken at bit ELEM_WIDTH-1
  logic [ELEM_WIDTH+mpe_pkg::VAL_W-1:0] raw;
  logic [ELEM_WIDTH-1:0]                elem;
  assign raw  = (ELEM_WIDTH + mpe_pkg::VAL_W)'($unsigned(in_word.value));
  assign elem = raw[ELEM_WIDTH-1:0];

  // load pointers
  logic [LW-1:0] a_idx_r, b_idx_r;
  logic          a_we, b_we;
  assign a_we = cmd.load_a && (a_idx_r < LW'(CAP));
  assign b_we = cmd.load_b && (b_idx_r < LW'(CAP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_idx_r <= '0;
      b_idx_r <= '0;
    end else if (cmd.rewind) begin
      a_idx_r <= '0;
      b_idx_r <= '0;
    end else begin
      if (a_we) a_idx_r <= a_idx_r + LW'(1);
      if (b_we) b_idx_r <= b_idx_r + LW'(1);
    end
  end

  // read addresses: a walks along a row, b steps down a column
  logic [AW-1:0] a_base_r, b_col_r, a_addr_r, b_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.rewind) begin
      a_base_r <= '0;
      b_col_r  <= '0;
    end else if (cmd.next_row) begin
      a_base_r <= a_base_r + AW'(ac);
      b_col_r  <= '0;
    end else if (cmd.next_col) begin
      b_col_r  <= b_col_r + AW'(1);
    end
    if (cmd.entry_init) begin
      a_addr_r <= a_base_r;
      b_addr_r <= b_col_r;
    end else if (cmd.term) begin
      a_addr_r <= a_addr_r + AW'(1);
      b_addr_r <= b_addr_r + AW'(bc);
    end
  end

  logic [ELEM_WIDTH-1:0] a_rd, b_rd;

  mpe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAP)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_idx_r[AW-1:0]),
    .wdata (elem),
    .raddr (a_addr_r),
    .rdata (a_rd)
  );

  mpe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAP)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_idx_r[AW-1:0]),
    .wdata (elem),
    .raddr (b_addr_r),
    .rdata (b_rd)
  );

  // mac pipeline: read data -> product -> accumulator
  logic s1_valid_r, s1_first_r, s1_last_r;
  logic s2_valid_r, s2_first_r, s2_last_r;
  logic acc_last_r;
  logic signed [ELEM_WIDTH-1:0] a_q, b_q;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;

  assign a_q = $signed(a_rd);
  assign b_q = $signed(b_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      acc_last_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.term;
      s2_valid_r <= s1_valid_r;
      acc_last_r <= s2_valid_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= a_q * b_q;
    if (s2_valid_r) begin
      if (s2_first_r) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // floor to q4.12 and clip
  logic signed [SAT_W-1:0]    acc_ext;
  logic [SAT_W-TOP_LO-1:0]    sat_top;
  logic                       in_range;
  logic signed [mpe_pkg::RES_W-1:0] res;

  assign acc_ext  = SAT_W'(acc_r);
  assign sat_top  = acc_ext[SAT_W-1:TOP_LO];
  assign in_range = (&sat_top) || !(|sat_top);
  assign res      = in_range ? acc_ext[TOP_LO:mpe_pkg::FRAC_BITS]
                  : (acc_ext[SAT_W-1] ? mpe_pkg::RES_MIN : mpe_pkg::RES_MAX);

  // result register
  logic               out_valid_r;
  mpe_pkg::out_word_t out_word_r;
  mpe_pkg::out_word_t err_word;

  // mismatch word: last and error set, everything else zero
  always_comb begin
    err_word       = '0;
    err_word.last  = 1'b1;
    err_word.error = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_last_r || cmd.err_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_emit) begin
      out_word_r           <= err_word;
    end else if (acc_last_r) begin
      out_word_r.result    <= res;
      out_word_r.row       <= cmd.row;
      out_word_r.col       <= cmd.col;
      out_word_r.last      <= cmd.last_entry;
      out_word_r.error     <= 1'b0;
      out_word_r.saturated <= !in_range;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.done     = acc_last_r;

endmodule

FILE: rtl/core/matrix_product_engine.sv
// top level of the matrix product engine: config registers, controller, datapath
`timescale 1ns / 1ps

// channel   ports                             word / meaning
// -------   -------------------------------   ---------------------------------------
// input     in_valid, in_stall, in_word       kind + q4.12 value: load a, load b, start
// result    out_valid, out_stall, out_word    one c entry (or one error word) per word
// config    psel penable pwrite paddr         a_rows a_cols b_rows b_cols at 4*i
//           pwdata prdata pready
//
// a load word is written straight into its store ram
// a start word runs every entry: a wait state, a mac issue per inner term, then the
//   pipeline (ram read, product, accumulate); a_cols != b_rows gives one error word
// the input side stalls from start until the last entry is in the result register
// each entry waits for the result register to drain before its mac run begins
// synchronous active-low reset clears control and sets all dimensions to 1

module matrix_product_engine #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  mpe_pkg::in_word_t  in_word,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output mpe_pkg::out_word_t out_word,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // dimension registers, raw as written
  logic [mpe_pkg::CFG_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic                      cfg_wr;
  logic [1:0]                cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= mpe_pkg::CFG_W'(1);
      a_cols_r <= mpe_pkg::CFG_W'(1);
      b_rows_r <= mpe_pkg::CFG_W'(1);
      b_cols_r <= mpe_pkg::CFG_W'(1);
    end else if (cfg_wr) begin
      case (cfg_sel)
        mpe_pkg::REG_A_ROWS: a_rows_r <= pwdata[mpe_pkg::CFG_W-1:0];
        mpe_pkg::REG_A_COLS: a_cols_r <= pwdata[mpe_pkg::CFG_W-1:0];
        mpe_pkg::REG_B_ROWS: b_rows_r <= pwdata[mpe_pkg::CFG_W-1:0];
        mpe_pkg::REG_B_COLS: b_cols_r <= pwdata[mpe_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back the raw register values
  always_comb begin
    case (cfg_sel)
      mpe_pkg::REG_A_ROWS: prdata = 32'(a_rows_r);
      mpe_pkg::REG_A_COLS: prdata = 32'(a_cols_r);
      mpe_pkg::REG_B_ROWS: prdata = 32'(b_rows_r);
      mpe_pkg::REG_B_COLS: prdata = 32'(b_cols_r);
      default:             prdata = '0;
    endcase
  end

  // zero counts as one, anything above the array size as the array size
  mpe_pkg::dims_t dims;
  localparam logic [mpe_pkg::CFG_W-1:0] MAX_D = mpe_pkg::CFG_W'(MAX_DIM);

  assign dims.ar = mpe_pkg::clip_dim(a_rows_r, MAX_D);
  assign dims.ac = mpe_pkg::clip_dim(a_cols_r, MAX_D);
  assign dims.br = mpe_pkg::clip_dim(b_rows_r, MAX_D);
  assign dims.bc = mpe_pkg::clip_dim(b_cols_r, MAX_D);

  mpe_pkg::cmd_t cmd;
  mpe_pkg::sts_t sts;

  // sequencer: accepts words, walks rows, columns and inner terms
  mpe_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, mac pipeline, saturation and the result register
  mpe_dp #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
